[rtl/cff_pkg.sv]
// ----------------------------------------------------------------------------
// cff_pkg: shared types and constants for the channel frame fragmenter
// Holds the channel payload structs, action codes, header flag codes and the
// result set that one input item produces.
// ----------------------------------------------------------------------------
package cff_pkg;

   localparam int RESULT_MAX = 8;
   localparam int RESULT_IDX_W = $clog2(RESULT_MAX);

   localparam logic [15:0] CHUNK_LIMIT_RESET = 16'd15000;
   localparam logic [31:0] MSG_LEN_MAX = 32'd65533;
   localparam logic [15:0] MSG_TYPE_CTRL_MAX = 16'd26;

   localparam logic [7:0] FLAGS_MIDDLE = 8'h00;
   localparam logic [7:0] FLAGS_FIRST = 8'h01;
   localparam logic [7:0] FLAGS_LAST = 8'h02;
   localparam logic [7:0] FLAGS_WHOLE = 8'h03;
   localparam logic [7:0] FLAGS_CTRL = 8'h07;

   typedef enum logic [1:0] {
      ACT_MEDIA_START = 2'd0,
      ACT_MSG_START   = 2'd1,
      ACT_DATA        = 2'd2,
      ACT_UNUSED      = 2'd3
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  channel;
      logic [15:0] msg_type;
      logic [31:0] total_len;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_frame;
      logic       end_of_payload;
      logic       error;
      logic       last;
   } rsp_type;

   // All results caused by one input item; last_idx points at the final one.
   typedef struct packed {
      rsp_type [RESULT_MAX-1:0]  entry;
      logic [RESULT_IDX_W-1:0]   last_idx;
   } frame_type;

   function automatic rsp_type make_rsp(input logic [7:0] b, input logic eof,
                                        input logic eop, input logic err);
      rsp_type r;
      r.out_byte = b;
      r.end_of_frame = eof;
      r.end_of_payload = eop;
      r.error = err;
      r.last = 1'b0;
      return r;
   endfunction

endpackage

[rtl/cff_framer.sv]
// ----------------------------------------------------------------------------
// cff_framer: header generation and payload tracking
// Keeps the payload state and builds the full result set for one input item
// in a single pass; state advances when the item is accepted.
// ----------------------------------------------------------------------------
module cff_framer
   import cff_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     item,
   input  logic [15:0] chunk_limit,
   output frame_type   frame
);

   logic        busy_ff, busy_in;
   logic [7:0]  channel_ff, channel_in;
   logic [31:0] left_total_ff, left_total_in;
   logic [15:0] left_chunk_ff, left_chunk_in;

   logic [15:0] lim;
   logic [31:0] lim_wide;
   logic        media_fits;
   logic        empty;
   logic [15:0] msg_len;
   logic [7:0]  msg_flags;
   logic [31:0] total_dec;
   logic [15:0] chunk_dec;
   logic        eop;
   logic        eof;
   logic        rem_fits;
   logic [15:0] next_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         channel_ff <= '0;
         left_total_ff <= '0;
         left_chunk_ff <= '0;
      end else if (accept) begin
         busy_ff <= busy_in;
         channel_ff <= channel_in;
         left_total_ff <= left_total_in;
         left_chunk_ff <= left_chunk_in;
      end
   end

   // A zero limit behaves as a limit of one byte.
   assign lim = (chunk_limit == '0) ? 16'd1 : chunk_limit;
   assign lim_wide = {16'd0, lim};
   assign media_fits = item.total_len <= lim_wide;
   assign empty = item.total_len == '0;
   assign msg_len = item.total_len[15:0] + 16'd2;
   assign msg_flags = (item.channel != '0 && item.msg_type <= MSG_TYPE_CTRL_MAX) ?
                      FLAGS_CTRL : FLAGS_WHOLE;
   assign total_dec = left_total_ff - 32'd1;
   assign chunk_dec = left_chunk_ff - 16'd1;
   assign eop = total_dec == '0;
   assign eof = eop || (chunk_dec == '0);
   assign rem_fits = total_dec <= lim_wide;
   assign next_len = rem_fits ? total_dec[15:0] : lim;

   always_comb begin
      frame = '0;
      busy_in = busy_ff;
      channel_in = channel_ff;
      left_total_in = left_total_ff;
      left_chunk_in = left_chunk_ff;

      // Rejected item: a single error result, state unchanged.
      frame.entry[0] = make_rsp(8'h00, 1'b0, 1'b0, 1'b1);
      frame.last_idx = '0;

      case (item.action)
         ACT_MEDIA_START, ACT_MSG_START: begin
            if (busy_ff) begin
               // Start while a payload is still open stays rejected.
            end else if (item.action == ACT_MSG_START) begin
               if (item.total_len <= MSG_LEN_MAX) begin
                  frame.entry[0] = make_rsp(item.channel, 1'b0, 1'b0, 1'b0);
                  frame.entry[1] = make_rsp(msg_flags, 1'b0, 1'b0, 1'b0);
                  frame.entry[2] = make_rsp(msg_len[15:8], 1'b0, 1'b0, 1'b0);
                  frame.entry[3] = make_rsp(msg_len[7:0], 1'b0, 1'b0, 1'b0);
                  frame.entry[4] = make_rsp(item.msg_type[15:8], 1'b0, 1'b0, 1'b0);
                  frame.entry[5] = make_rsp(item.msg_type[7:0], empty, empty, 1'b0);
                  frame.last_idx = RESULT_IDX_W'(5);
                  channel_in = item.channel;
                  left_total_in = item.total_len;
                  left_chunk_in = item.total_len[15:0];
                  busy_in = !empty;
               end
            end else if (media_fits) begin
               frame.entry[0] = make_rsp(item.channel, 1'b0, 1'b0, 1'b0);
               frame.entry[1] = make_rsp(FLAGS_WHOLE, 1'b0, 1'b0, 1'b0);
               frame.entry[2] = make_rsp(item.total_len[15:8], 1'b0, 1'b0, 1'b0);
               frame.entry[3] = make_rsp(item.total_len[7:0], empty, empty, 1'b0);
               frame.last_idx = RESULT_IDX_W'(3);
               channel_in = item.channel;
               left_total_in = item.total_len;
               left_chunk_in = item.total_len[15:0];
               busy_in = !empty;
            end else begin
               frame.entry[0] = make_rsp(item.channel, 1'b0, 1'b0, 1'b0);
               frame.entry[1] = make_rsp(FLAGS_FIRST, 1'b0, 1'b0, 1'b0);
               frame.entry[2] = make_rsp(lim[15:8], 1'b0, 1'b0, 1'b0);
               frame.entry[3] = make_rsp(lim[7:0], 1'b0, 1'b0, 1'b0);
               frame.entry[4] = make_rsp(item.total_len[31:24], 1'b0, 1'b0, 1'b0);
               frame.entry[5] = make_rsp(item.total_len[23:16], 1'b0, 1'b0, 1'b0);
               frame.entry[6] = make_rsp(item.total_len[15:8], 1'b0, 1'b0, 1'b0);
               frame.entry[7] = make_rsp(item.total_len[7:0], 1'b0, 1'b0, 1'b0);
               frame.last_idx = RESULT_IDX_W'(7);
               channel_in = item.channel;
               left_total_in = item.total_len;
               left_chunk_in = lim;
               busy_in = 1'b1;
            end
         end
         ACT_DATA: begin
            if (busy_ff && left_total_ff != '0 && left_chunk_ff != '0) begin
               frame.entry[0] = make_rsp(item.data_byte, eof, eop, 1'b0);
               frame.last_idx = '0;
               left_total_in = total_dec;
               if (eop) begin
                  busy_in = 1'b0;
                  left_chunk_in = '0;
               end else if (chunk_dec == '0) begin
                  // The byte closes a fragment: the next header follows it.
                  frame.entry[1] = make_rsp(channel_ff, 1'b0, 1'b0, 1'b0);
                  frame.entry[2] = make_rsp(rem_fits ? FLAGS_LAST : FLAGS_MIDDLE,
                                            1'b0, 1'b0, 1'b0);
                  frame.entry[3] = make_rsp(next_len[15:8], 1'b0, 1'b0, 1'b0);
                  frame.entry[4] = make_rsp(next_len[7:0], 1'b0, 1'b0, 1'b0);
                  frame.last_idx = RESULT_IDX_W'(4);
                  left_chunk_in = next_len;
               end else begin
                  left_chunk_in = chunk_dec;
               end
            end
         end
         default: begin
            // Unknown action stays rejected.
         end
      endcase
   end

endmodule

[rtl/channel_frame_fragmenter_unit.sv]
// ----------------------------------------------------------------------------
// channel_frame_fragmenter_unit: frames payload bytes for a channel link
// The first result of an item is offered in the cycle after its transfer.
// An item holds the result register until its last result is taken, so a
// plain data byte (one result) can follow in every cycle while rsp_stall is low.
// The result register drains one result per cycle while it is not stalled.
// Reset (synchronous) closes any open payload, empties the result register and
// restores the chunk limit to 15000.
// ----------------------------------------------------------------------------
module channel_frame_fragmenter_unit
   import cff_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   // Chunk limit register. Writes must arrive only while the block is idle; the
   // block itself does not enforce this. The port is always ready.
   logic [15:0] chunk_limit_ff;

   // Result register: every result of the item last accepted, plus the
   // position of the one currently offered on the result channel.
   logic                    out_valid_ff;
   frame_type               out_frame_ff;
   logic [RESULT_IDX_W-1:0] out_idx_ff;

   frame_type new_frame;
   logic      req_accept;
   logic      rsp_take;
   logic      frame_done;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_limit_ff <= CHUNK_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         chunk_limit_ff <= csr_data;
      end
   end

   // Header generation and payload bookkeeping for one item, in one pass.
   cff_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .item        (req_data),
      .chunk_limit (chunk_limit_ff),
      .frame       (new_frame)
   );

   // A transfer on the result channel takes the current entry; the frame is
   // done once its final entry goes out. The next item may then enter in the
   // same cycle, so the input is held off only while results still remain.
   assign rsp_take = out_valid_ff && !rsp_stall;
   assign frame_done = rsp_take && (out_idx_ff == out_frame_ff.last_idx);
   assign req_stall = out_valid_ff && !frame_done;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_idx_ff <= '0;
      end else if (req_accept) begin
         out_valid_ff <= 1'b1;
         out_idx_ff <= '0;
      end else if (frame_done) begin
         out_valid_ff <= 1'b0;
      end else if (rsp_take) begin
         out_idx_ff <= out_idx_ff + RESULT_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         out_frame_ff <= new_frame;
      end
   end

   // The offered result comes straight from the register, so it holds steady
   // while the channel is stalled.
   always_comb begin
      rsp_data = out_frame_ff.entry[out_idx_ff];
      rsp_data.last = out_idx_ff == out_frame_ff.last_idx;
   end

   assign rsp_valid = out_valid_ff;

endmodule
